/* rtl/scs_pkg.sv */
// Shared types and constants of the shadow call stack monitor.
`timescale 1ns / 1ps

package scs_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned INT_W      = 8;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned BRK_W      = 6;

  // Call-site and function addresses are compared with bit 0 cleared.
  localparam logic [ADDR_W-1:0] ADDR_MASK = 32'hFFFF_FFFE;

  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_ENABLE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_DEPTH  = 4'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENTER   = 3'd0,
    KIND_EXIT    = 3'd1,
    KIND_SETJMP  = 3'd2,
    KIND_LONGJMP = 3'd3,
    KIND_READ    = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK            = 3'd0,
    STS_BREAK         = 3'd1,
    STS_OVERFLOW      = 3'd2,
    STS_FN_MISMATCH   = 3'd3,
    STS_SITE_MISMATCH = 3'd4,
    STS_NO_MATCH      = 3'd5,
    STS_JMP_OVERFLOW  = 3'd6,
    STS_HALTED        = 3'd7
  } status_e;

  typedef enum logic {
    STATE_IDLE = 1'b0,
    STATE_EXEC = 1'b1
  } state_e;

  // One call stack entry as it sits in the stack memory.
  typedef struct packed {
    logic [ADDR_W-1:0] fn;
    logic [ADDR_W-1:0] site;
    logic [INT_W-1:0]  intn;
  } entry_t;

endpackage

/* rtl/scs_if.sv */
// Handshake interfaces of the shadow call stack monitor: events, results and configuration.
`timescale 1ns / 1ps

interface scs_in_if;
  logic                           valid;
  logic                           ready;
  logic [scs_pkg::KIND_W-1:0]     kind;
  logic [scs_pkg::ADDR_W-1:0]     fn_addr;
  logic [scs_pkg::ADDR_W-1:0]     site_addr;
  logic [scs_pkg::INT_W-1:0]      int_num;
  logic [scs_pkg::ADDR_W-1:0]     jmp_addr;
  logic [scs_pkg::IDX_W-1:0]      entry_index;

  modport source (
    output valid, kind, fn_addr, site_addr, int_num, jmp_addr, entry_index,
    input  ready
  );
  modport sink (
    input  valid, kind, fn_addr, site_addr, int_num, jmp_addr, entry_index,
    output ready
  );
endinterface

interface scs_out_if #(
  parameter int unsigned DEPTH_W = 7
);
  logic                           valid;
  logic                           ready;
  logic [scs_pkg::STATUS_W-1:0]   status;
  logic [DEPTH_W-1:0]             depth;
  logic [scs_pkg::ADDR_W-1:0]     entry_fn;
  logic [scs_pkg::ADDR_W-1:0]     entry_site;
  logic [scs_pkg::INT_W-1:0]      entry_int;

  modport source (
    output valid, status, depth, entry_fn, entry_site, entry_int,
    input  ready
  );
  modport sink (
    input  valid, status, depth, entry_fn, entry_site, entry_int,
    output ready
  );
endinterface

interface scs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [scs_pkg::CFG_IDX_W-1:0]   index;
  logic [scs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/shadow_call_stack_monitor.sv */
// Top level of the shadow call stack monitor: sequencer, control state and result register.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake     Payload
//  in_i     sink       valid/ready   kind, fn_addr, site_addr, int_num, jmp_addr, entry_index
//  out_o    source     valid/ready   status, depth, entry_fn, entry_site, entry_int
//  cfg_i    sink       valid/ready   index, data (break_enable, break_depth)
//
//  Every event passes through the transfer cycle, which also issues the reads of the stack
//  memory and the jump record memory, and then the execute state that checks the read data.
//  A longjmp stays in the execute state and issues another read for each jump record it
//  checks and rejects, since the search walks the single read port of the jump record memory
//  downward. The result register lets a new event transfer while a result waits; the execute
//  state holds while that register is still full. Reset clears depth, jump count, halt and the
//  configuration at once; the memories have no clearing pass and are undefined until written.

module shadow_call_stack_monitor #(
  parameter int unsigned STACK_ENTRIES = 64,
  parameter int unsigned JMP_ENTRIES   = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  scs_in_if.sink   in_i,
  scs_out_if.source out_o,
  scs_cfg_if.sink  cfg_i
);

  localparam int unsigned DEPTH_W = $clog2(STACK_ENTRIES + 1);
  localparam int unsigned AW      = $clog2(STACK_ENTRIES);
  localparam int unsigned JAW     = (JMP_ENTRIES > 1) ? $clog2(JMP_ENTRIES) : 1;
  localparam int unsigned JCW     = $clog2(JMP_ENTRIES + 1);
  localparam int unsigned JW      = scs_pkg::ADDR_W + DEPTH_W;
  localparam int unsigned EW      = $bits(scs_pkg::entry_t);

  // Sequencer and architectural state.
  scs_pkg::state_e state_q, state_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [JCW-1:0]     jcnt_q, jcnt_d;
  logic [JCW-1:0]     search_q, search_d;
  logic               halted_q, halted_d;

  // Configuration registers.
  logic                    brk_en_q;
  logic [scs_pkg::BRK_W-1:0] brk_depth_q;

  // The event under execution.
  logic [scs_pkg::KIND_W-1:0] kind_q;
  logic [scs_pkg::ADDR_W-1:0] fn_q;
  logic [scs_pkg::ADDR_W-1:0] site_q;
  logic [scs_pkg::INT_W-1:0]  int_q;
  logic [scs_pkg::ADDR_W-1:0] jaddr_q;
  logic [scs_pkg::IDX_W-1:0]  idx_q;

  // Result register.
  logic                       out_valid_q, out_valid_d;
  scs_pkg::status_e           out_status_q;
  logic [DEPTH_W-1:0]         out_depth_q;
  scs_pkg::entry_t            out_entry_q;

  // Memory ports.
  logic                 smem_we, smem_re;
  logic [AW-1:0]        smem_waddr, smem_raddr;
  scs_pkg::entry_t      smem_wdata, smem_rdata;
  logic [EW-1:0]        smem_rvec;
  logic                 jmem_we, jmem_re;
  logic [JAW-1:0]       jmem_waddr, jmem_raddr;
  logic [JW-1:0]        jmem_wdata, jmem_rdata;

  logic                 accept, out_free, done, commit;
  scs_pkg::status_e     status;
  scs_pkg::entry_t      entry;
  logic                 do_push, do_pop, do_setjmp, do_longjmp;
  logic [DEPTH_W-1:0]   depth_m1;
  logic [JCW-1:0]       search_m1;
  logic                 read_hit;

  assign in_i.ready  = (state_q == scs_pkg::STATE_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  assign depth_m1  = depth_q - DEPTH_W'(1);
  assign search_m1 = search_q - JCW'(1);
  assign smem_rdata = smem_rvec;

  // A read returns an entry only below the current depth.
  assign read_hit = (32'(idx_q) < 32'(depth_q)) && (32'(idx_q) < STACK_ENTRIES);

  always_comb begin
    state_d    = state_q;
    search_d   = search_q;
    smem_re    = 1'b0;
    smem_raddr = AW'(in_i.entry_index);
    jmem_re    = 1'b0;
    jmem_raddr = JAW'(jcnt_q - JCW'(1));
    done       = 1'b0;
    status     = scs_pkg::STS_OK;
    entry      = '0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_setjmp  = 1'b0;
    do_longjmp = 1'b0;

    case (state_q)
      scs_pkg::STATE_IDLE: begin
        if (accept) begin
          // Both memories are read speculatively; an exit reads the top stack entry.
          state_d  = scs_pkg::STATE_EXEC;
          smem_re  = 1'b1;
          jmem_re  = 1'b1;
          search_d = jcnt_q;
          if (in_i.kind == scs_pkg::KIND_EXIT) begin
            smem_raddr = AW'(depth_m1);
          end
        end
      end
      scs_pkg::STATE_EXEC: begin
        done = 1'b1;
        if (kind_q == scs_pkg::KIND_READ) begin
          status = halted_q ? scs_pkg::STS_HALTED : scs_pkg::STS_OK;
          if (read_hit) begin
            entry = smem_rdata;
          end
        end else if (halted_q) begin
          status = scs_pkg::STS_HALTED;
        end else begin
          case (scs_pkg::kind_e'(kind_q))
            scs_pkg::KIND_ENTER: begin
              // The breakpoint takes precedence over the overflow check.
              if (brk_en_q && (32'(depth_q) == 32'(brk_depth_q))) begin
                status = scs_pkg::STS_BREAK;
              end else if (32'(depth_q) >= STACK_ENTRIES) begin
                status = scs_pkg::STS_OVERFLOW;
              end else begin
                do_push = 1'b1;
              end
            end
            scs_pkg::KIND_EXIT: begin
              // An exit at depth zero is ignored.
              if (depth_q != '0) begin
                if (smem_rdata.fn != (fn_q & scs_pkg::ADDR_MASK)) begin
                  status = scs_pkg::STS_FN_MISMATCH;
                end else if (smem_rdata.site != (site_q & scs_pkg::ADDR_MASK)) begin
                  status = scs_pkg::STS_SITE_MISMATCH;
                end else begin
                  do_pop = 1'b1;
                end
              end
            end
            scs_pkg::KIND_SETJMP: begin
              if (32'(jcnt_q) >= JMP_ENTRIES) begin
                status = scs_pkg::STS_JMP_OVERFLOW;
              end else begin
                do_setjmp = 1'b1;
              end
            end
            scs_pkg::KIND_LONGJMP: begin
              // The read data holds record search_q - 1; a miss steps one record down.
              if (search_q == '0) begin
                status = scs_pkg::STS_NO_MATCH;
              end else if (jmem_rdata[JW-1 -: scs_pkg::ADDR_W] == jaddr_q) begin
                do_longjmp = 1'b1;
              end else begin
                done       = 1'b0;
                search_d   = search_m1;
                jmem_re    = 1'b1;
                jmem_raddr = JAW'(search_m1 - JCW'(1));
              end
            end
            default: begin
              status = scs_pkg::STS_OK;
            end
          endcase
        end
      end
      default: begin
        state_d = scs_pkg::STATE_IDLE;
      end
    endcase

    commit = done && out_free;
    if (commit) begin
      state_d = scs_pkg::STATE_IDLE;
    end
  end

  // State updates happen only when the result is taken into the result register.
  always_comb begin
    depth_d  = depth_q;
    jcnt_d   = jcnt_q;
    halted_d = halted_q;
    if (commit) begin
      halted_d = halted_q || (status != scs_pkg::STS_OK);
      if (do_push) begin
        depth_d = depth_q + DEPTH_W'(1);
      end
      if (do_pop) begin
        depth_d = depth_m1;
      end
      if (do_setjmp) begin
        jcnt_d = jcnt_q + JCW'(1);
      end
      if (do_longjmp) begin
        jcnt_d  = search_m1;
        depth_d = jmem_rdata[DEPTH_W-1:0];
      end
    end
    out_valid_d = out_valid_q && !out_o.ready;
    if (commit) begin
      out_valid_d = 1'b1;
    end
  end

  assign smem_we    = commit && do_push;
  assign smem_waddr = AW'(depth_q);
  assign smem_wdata = '{fn:   fn_q & scs_pkg::ADDR_MASK,
                        site: site_q & scs_pkg::ADDR_MASK,
                        intn: int_q};
  assign jmem_we    = commit && do_setjmp;
  assign jmem_waddr = JAW'(jcnt_q);
  assign jmem_wdata = {jaddr_q, depth_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scs_pkg::STATE_IDLE;
      depth_q     <= '0;
      jcnt_q      <= '0;
      search_q    <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      jcnt_q      <= jcnt_d;
      search_q    <= search_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration writes should arrive only while no event is in flight; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_en_q    <= 1'b0;
      brk_depth_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        scs_pkg::CFG_BREAK_ENABLE: brk_en_q    <= cfg_i.data[0];
        scs_pkg::CFG_BREAK_DEPTH:  brk_depth_q <= cfg_i.data[scs_pkg::BRK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= in_i.kind;
      fn_q    <= in_i.fn_addr;
      site_q  <= in_i.site_addr;
      int_q   <= in_i.int_num;
      jaddr_q <= in_i.jmp_addr;
      idx_q   <= in_i.entry_index;
    end
  end

  // The depth reported is the one after the event.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_status_q <= status;
      out_depth_q  <= depth_d;
      out_entry_q  <= entry;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.depth      = out_depth_q;
  assign out_o.entry_fn   = out_entry_q.fn;
  assign out_o.entry_site = out_entry_q.site;
  assign out_o.entry_int  = out_entry_q.intn;

  scs_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_ENTRIES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (smem_we),
    .waddr_i (smem_waddr),
    .wdata_i (smem_wdata),
    .re_i    (smem_re),
    .raddr_i (smem_raddr),
    .rdata_o (smem_rvec)
  );

  scs_ram #(
    .WIDTH (JW),
    .DEPTH (JMP_ENTRIES)
  ) u_jmp_ram (
    .clk_i   (clk_i),
    .we_i    (jmem_we),
    .waddr_i (jmem_waddr),
    .wdata_i (jmem_wdata),
    .re_i    (jmem_re),
    .raddr_i (jmem_raddr),
    .rdata_o (jmem_rdata)
  );

endmodule

/* rtl/scs_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module scs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
